// ===== rtl/hra_pkg.sv =====
// Package with the shared types and constants of the heart-rate source arbiter.
`timescale 1ns / 1ps

package hra_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_HR_STALE_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_LEAD_STALE_LIMIT = 2'd1;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] STALE_LIMIT_RESET = 16'd5000;
   localparam logic [11:0] SPO2_SCALE        = 12'd10;

   // Message kinds
   localparam logic CMD_ECG = 1'b0;
   localparam logic CMD_PPG = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;

   // A request after classification by the front part
   typedef struct packed {
      logic        is_ppg;
      logic [31:0] now_ms;
      logic        mask_off;
      logic [15:0] rate_bpm;
      logic [15:0] sdnn_ms;
      logic [15:0] rmssd_ms;
      logic [7:0]  lf_hf_x10;
      logic [11:0] spo2_scaled;
      logic        poor_signal;
   } entry_type;

   // Handshake between the queue and the back part
   typedef struct packed {
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic not_empty;
   } queue_status_type;

endpackage

// ===== rtl/hra_front.sv =====
// Front part: classifies an incoming request and precomputes its derived values.
`timescale 1ns / 1ps

module hra_front (
   input  logic                 req_cmd,
   input  logic [31:0]          req_now_ms,
   input  logic [7:0]           req_lead_mask,
   input  logic [31:0]          req_lead_mask_age_ms,
   input  logic [15:0]          req_rate_bpm,
   input  logic [15:0]          req_sdnn_ms,
   input  logic [15:0]          req_rmssd_ms,
   input  logic                 req_freq_valid,
   input  logic [7:0]           req_lf_hf_ratio_x10,
   input  logic [7:0]           req_spo2_pct,
   input  logic                 req_low_perfusion,
   input  logic                 req_finger_off,
   input  logic [15:0]          lead_stale_limit,
   output hra_pkg::entry_type   entry
);

   always_comb begin
      entry.is_ppg      = (req_cmd == hra_pkg::CMD_PPG);
      entry.now_ms      = req_now_ms;
      // An old mask is treated as unknown, so it cannot block the ECG rate.
      entry.mask_off    = (req_lead_mask_age_ms <= {16'd0, lead_stale_limit})
                          && (req_lead_mask != 8'd0);
      entry.rate_bpm    = req_rate_bpm;
      entry.sdnn_ms     = req_sdnn_ms;
      entry.rmssd_ms    = req_rmssd_ms;
      entry.lf_hf_x10   = req_freq_valid ? req_lf_hf_ratio_x10 : 8'd0;
      entry.spo2_scaled = {4'd0, req_spo2_pct} * hra_pkg::SPO2_SCALE;
      entry.poor_signal = req_low_perfusion | req_finger_off;
   end

endmodule

// ===== rtl/hra_queue.sv =====
// Short register queue between the front and back parts.
`timescale 1ns / 1ps

module hra_queue #(
   parameter int unsigned DEPTH = hra_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hra_pkg::entry_type        push_entry,
   output logic                      full,
   input  hra_pkg::queue_ctrl_type   ctrl,
   output hra_pkg::queue_status_type status,
   output hra_pkg::entry_type        head_entry
);

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   hra_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full             = (count_ff == FULL_COUNT);
   assign status.not_empty = (count_ff != '0);
   assign head_entry       = slot_ff[rd_ptr_ff];
   assign do_push          = push && !full;
   assign do_pop           = ctrl.pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/hra_back.sv =====
// Back part: keeps the stored vitals, picks the rate source and registers the result.
`timescale 1ns / 1ps

module hra_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hra_pkg::queue_status_type status,
   input  hra_pkg::entry_type        head_entry,
   output hra_pkg::queue_ctrl_type   ctrl,
   input  logic [15:0]               hr_stale_limit,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_hr_out_bpm,
   output logic                      rsp_hr_from_ppg,
   output logic                      rsp_ecg_leads_off,
   output logic                      rsp_ppg_weak,
   output logic [11:0]               rsp_spo2_x10,
   output logic [15:0]               rsp_sdnn_out_ms,
   output logic [15:0]               rsp_rmssd_out_ms,
   output logic [7:0]                rsp_lf_hf_out_x10
);

   logic [15:0] ecg_rate_ff, ecg_rate_in;
   logic [31:0] ecg_time_ff, ecg_time_in;
   logic [15:0] ppg_rate_ff, ppg_rate_in;
   logic [31:0] ppg_time_ff, ppg_time_in;
   logic        weak_ff, weak_in;
   logic [11:0] spo2_ff, spo2_in;
   logic [15:0] sdnn_ff, sdnn_in;
   logic [15:0] rmssd_ff, rmssd_in;
   logic [7:0]  lf_hf_ff, lf_hf_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] hr_ff, hr_in;
   logic        from_ppg_ff, from_ppg_in;
   logic        leads_off_ff;

   logic [31:0] ecg_age;
   logic [31:0] ppg_age;
   logic        ecg_ok;
   logic        ppg_ok;
   logic        take;

   // The output register frees up either when empty or when its request leaves.
   assign take     = status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign ctrl.pop = take;

   always_comb begin
      ecg_rate_in = ecg_rate_ff;
      ecg_time_in = ecg_time_ff;
      ppg_rate_in = ppg_rate_ff;
      ppg_time_in = ppg_time_ff;
      weak_in     = weak_ff;
      spo2_in     = spo2_ff;
      sdnn_in     = sdnn_ff;
      rmssd_in    = rmssd_ff;
      lf_hf_in    = lf_hf_ff;

      if (head_entry.is_ppg) begin
         ppg_rate_in = head_entry.rate_bpm;
         ppg_time_in = head_entry.now_ms;
         weak_in     = head_entry.poor_signal;
         spo2_in     = head_entry.spo2_scaled;
      end else begin
         ecg_rate_in = head_entry.rate_bpm;
         ecg_time_in = head_entry.now_ms;
         sdnn_in     = head_entry.sdnn_ms;
         rmssd_in    = head_entry.rmssd_ms;
         lf_hf_in    = head_entry.lf_hf_x10;
      end

      // Ages are wrapping differences of the 32-bit uptime.
      ecg_age = head_entry.now_ms - ecg_time_in;
      ppg_age = head_entry.now_ms - ppg_time_in;
      ecg_ok  = !head_entry.mask_off && (ecg_rate_in != 16'd0)
                && (ecg_age <= {16'd0, hr_stale_limit});
      ppg_ok  = (ppg_rate_in != 16'd0) && (ppg_age <= {16'd0, hr_stale_limit});

      hr_in       = 16'd0;
      from_ppg_in = 1'b0;
      priority if (ecg_ok) begin
         hr_in = ecg_rate_in;
      end else if (ppg_ok) begin
         hr_in       = ppg_rate_in;
         from_ppg_in = 1'b1;
      end

      // HRV values are cleared as soon as the ECG rate is unusable.
      if (!ecg_ok) begin
         sdnn_in  = 16'd0;
         rmssd_in = 16'd0;
         lf_hf_in = 8'd0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecg_rate_ff  <= '0;
         ecg_time_ff  <= '0;
         ppg_rate_ff  <= '0;
         ppg_time_ff  <= '0;
         weak_ff      <= 1'b0;
         spo2_ff      <= '0;
         sdnn_ff      <= '0;
         rmssd_ff     <= '0;
         lf_hf_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            ecg_rate_ff <= ecg_rate_in;
            ecg_time_ff <= ecg_time_in;
            ppg_rate_ff <= ppg_rate_in;
            ppg_time_ff <= ppg_time_in;
            weak_ff     <= weak_in;
            spo2_ff     <= spo2_in;
            sdnn_ff     <= sdnn_in;
            rmssd_ff    <= rmssd_in;
            lf_hf_ff    <= lf_hf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hr_ff        <= hr_in;
         from_ppg_ff  <= from_ppg_in;
         leads_off_ff <= head_entry.mask_off;
      end
   end

   // The stored values themselves form the rest of the result.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hr_out_bpm    = hr_ff;
   assign rsp_hr_from_ppg   = from_ppg_ff;
   assign rsp_ecg_leads_off = leads_off_ff;
   assign rsp_ppg_weak      = weak_ff;
   assign rsp_spo2_x10      = spo2_ff;
   assign rsp_sdnn_out_ms   = sdnn_ff;
   assign rsp_rmssd_out_ms  = rmssd_ff;
   assign rsp_lf_hf_out_x10 = lf_hf_ff;

endmodule

// ===== rtl/heart_rate_source_arbiter.sv =====
// Top level of the heart-rate source arbiter: configuration registers and the two parts.
//
//   Channel  Ports   Direction  Carries
//   req      req_*   in         one ECG or PPG vitals message per request
//   rsp      rsp_*   out        one merged vitals record per request
//   csr      csr_*   in         writes to the two staleness limits
//
// A request is classified on entry and queued; while rsp_stall is low the back part
// takes one request per cycle, so the block sustains one request per cycle. A request
// passes through a queue slot register and then the output register on its way out. The
// queue depth sets how many further requests the input accepts while rsp_stall is held.
// Reset is synchronous and clears the stored vitals, the queue and the limits to
// 5000 ms; no clearing pass is needed.
`timescale 1ns / 1ps

module heart_rate_source_arbiter #(
   parameter int unsigned QUEUE_DEPTH = hra_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [31:0]                          req_now_ms,
   input  logic [7:0]                           req_lead_mask,
   input  logic [31:0]                          req_lead_mask_age_ms,
   input  logic [15:0]                          req_rate_bpm,
   input  logic [15:0]                          req_sdnn_ms,
   input  logic [15:0]                          req_rmssd_ms,
   input  logic                                 req_freq_valid,
   input  logic [7:0]                           req_lf_hf_ratio_x10,
   input  logic [7:0]                           req_spo2_pct,
   input  logic                                 req_low_perfusion,
   input  logic                                 req_finger_off,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_hr_out_bpm,
   output logic                                 rsp_hr_from_ppg,
   output logic                                 rsp_ecg_leads_off,
   output logic                                 rsp_ppg_weak,
   output logic [11:0]                          rsp_spo2_x10,
   output logic [15:0]                          rsp_sdnn_out_ms,
   output logic [15:0]                          rsp_rmssd_out_ms,
   output logic [7:0]                           rsp_lf_hf_out_x10,
   input  logic                                 csr_we,
   input  logic [hra_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [hra_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [15:0] hr_stale_limit_ff;
   logic [15:0] lead_stale_limit_ff;

   hra_pkg::entry_type        front_entry;
   hra_pkg::entry_type        head_entry;
   hra_pkg::queue_ctrl_type   queue_ctrl;
   hra_pkg::queue_status_type queue_status;
   logic                      queue_full;

   // Writes to an index beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         hr_stale_limit_ff   <= hra_pkg::STALE_LIMIT_RESET;
         lead_stale_limit_ff <= hra_pkg::STALE_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            hra_pkg::CSR_HR_STALE_LIMIT: begin
               hr_stale_limit_ff <= csr_wdata;
            end
            hra_pkg::CSR_LEAD_STALE_LIMIT: begin
               lead_stale_limit_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall = queue_full;

   hra_front u_front (
      .req_cmd              (req_cmd),
      .req_now_ms           (req_now_ms),
      .req_lead_mask        (req_lead_mask),
      .req_lead_mask_age_ms (req_lead_mask_age_ms),
      .req_rate_bpm         (req_rate_bpm),
      .req_sdnn_ms          (req_sdnn_ms),
      .req_rmssd_ms         (req_rmssd_ms),
      .req_freq_valid       (req_freq_valid),
      .req_lf_hf_ratio_x10  (req_lf_hf_ratio_x10),
      .req_spo2_pct         (req_spo2_pct),
      .req_low_perfusion    (req_low_perfusion),
      .req_finger_off       (req_finger_off),
      .lead_stale_limit     (lead_stale_limit_ff),
      .entry                (front_entry)
   );

   hra_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .push_entry (front_entry),
      .full       (queue_full),
      .ctrl       (queue_ctrl),
      .status     (queue_status),
      .head_entry (head_entry)
   );

   hra_back u_back (
      .clock             (clock),
      .reset             (reset),
      .status            (queue_status),
      .head_entry        (head_entry),
      .ctrl              (queue_ctrl),
      .hr_stale_limit    (hr_stale_limit_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hr_out_bpm    (rsp_hr_out_bpm),
      .rsp_hr_from_ppg   (rsp_hr_from_ppg),
      .rsp_ecg_leads_off (rsp_ecg_leads_off),
      .rsp_ppg_weak      (rsp_ppg_weak),
      .rsp_spo2_x10      (rsp_spo2_x10),
      .rsp_sdnn_out_ms   (rsp_sdnn_out_ms),
      .rsp_rmssd_out_ms  (rsp_rmssd_out_ms),
      .rsp_lf_hf_out_x10 (rsp_lf_hf_out_x10)
   );

endmodule

// ===== sim/vitals_merge_checker.sv =====
// Checker for the heart-rate source arbiter: predicts each merged record and compares it.
`timescale 1ns / 1ps

module vitals_merge_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [31:0]                         req_now_ms,
   input  logic [7:0]                          req_lead_mask,
   input  logic [31:0]                         req_lead_mask_age_ms,
   input  logic [15:0]                         req_rate_bpm,
   input  logic [15:0]                         req_sdnn_ms,
   input  logic [15:0]                         req_rmssd_ms,
   input  logic                                req_freq_valid,
   input  logic [7:0]                          req_lf_hf_ratio_x10,
   input  logic [7:0]                          req_spo2_pct,
   input  logic                                req_low_perfusion,
   input  logic                                req_finger_off,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [15:0]                         rsp_hr_out_bpm,
   input  logic                                rsp_hr_from_ppg,
   input  logic                                rsp_ecg_leads_off,
   input  logic                                rsp_ppg_weak,
   input  logic [11:0]                         rsp_spo2_x10,
   input  logic [15:0]                         rsp_sdnn_out_ms,
   input  logic [15:0]                         rsp_rmssd_out_ms,
   input  logic [7:0]                          rsp_lf_hf_out_x10,
   input  logic                                csr_we,
   input  logic [hra_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hra_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  records_waiting
);

   typedef struct packed {
      logic [15:0] hr_bpm;
      logic        from_ppg;
      logic        lead_off_flag;
      logic        poor_ppg;
      logic [11:0] spo2_scaled;
      logic [15:0] sdnn_ms;
      logic [15:0] rmssd_ms;
      logic [7:0]  lf_hf_x10;
   } vitals_record_type;

   vitals_record_type pending_records[$];
   vitals_record_type predicted;
   vitals_record_type oldest;

   // Our own copy of the limits and of the stored vitals.
   logic [15:0] hr_limit;
   logic [15:0] lead_limit;
   logic [15:0] ecg_rate;
   logic [31:0] ecg_time;
   logic [15:0] ppg_bpm;
   logic [31:0] ppg_time;
   logic        weak_mark;
   logic [11:0] spo2_keep;
   logic [15:0] sdnn_keep;
   logic [15:0] rmssd_keep;
   logic [7:0]  lf_hf_keep;

   logic [31:0] ecg_age;
   logic [31:0] ppg_age;
   logic        leads_off_now;
   logic        ecg_usable;
   logic        ppg_usable;

   initial begin
      fail_count = 0;
      records_waiting = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hr_limit = hra_pkg::STALE_LIMIT_RESET;
         lead_limit = hra_pkg::STALE_LIMIT_RESET;
         ecg_rate = '0;
         ecg_time = '0;
         ppg_bpm = '0;
         ppg_time = '0;
         weak_mark = 1'b0;
         spo2_keep = '0;
         sdnn_keep = '0;
         rmssd_keep = '0;
         lf_hf_keep = '0;
         pending_records.delete();
      end else begin
         if (csr_we) begin
            // Writes to an index other than the two limits are ignored.
            if (csr_index == hra_pkg::CSR_HR_STALE_LIMIT) hr_limit = csr_wdata;
            else if (csr_index == hra_pkg::CSR_LEAD_STALE_LIMIT) lead_limit = csr_wdata;
         end

         if (req_valid && !req_stall) begin
            if (req_cmd == hra_pkg::CMD_ECG) begin
               ecg_rate = req_rate_bpm;
               ecg_time = req_now_ms;
               sdnn_keep = req_sdnn_ms;
               rmssd_keep = req_rmssd_ms;
               lf_hf_keep = req_freq_valid ? req_lf_hf_ratio_x10 : 8'd0;
            end else begin
               ppg_bpm = req_rate_bpm;
               ppg_time = req_now_ms;
               spo2_keep = {4'd0, req_spo2_pct} * hra_pkg::SPO2_SCALE;
               weak_mark = req_low_perfusion | req_finger_off;
            end

            // A lead-off mask older than its limit is taken as unknown, i.e. leads on.
            leads_off_now = (req_lead_mask_age_ms <= {16'd0, lead_limit}) &&
                            (req_lead_mask != 8'd0);
            ecg_age = req_now_ms - ecg_time;
            ppg_age = req_now_ms - ppg_time;
            ecg_usable = !leads_off_now && (ecg_rate != 16'd0) &&
                         (ecg_age <= {16'd0, hr_limit});
            ppg_usable = (ppg_bpm != 16'd0) && (ppg_age <= {16'd0, hr_limit});

            if (!ecg_usable) begin
               sdnn_keep = '0;
               rmssd_keep = '0;
               lf_hf_keep = '0;
            end

            predicted.hr_bpm = ecg_usable ? ecg_rate : (ppg_usable ? ppg_bpm : 16'd0);
            predicted.from_ppg = !ecg_usable && ppg_usable;
            predicted.lead_off_flag = leads_off_now;
            predicted.poor_ppg = weak_mark;
            predicted.spo2_scaled = spo2_keep;
            predicted.sdnn_ms = sdnn_keep;
            predicted.rmssd_ms = rmssd_keep;
            predicted.lf_hf_x10 = lf_hf_keep;
            pending_records.push_back(predicted);
         end

         if (rsp_valid && !rsp_stall) begin
            if (pending_records.size() == 0) begin
               report_mismatch($sformatf("record with rate %0d arrived with no request waiting",
                                         rsp_hr_out_bpm));
            end else begin
               oldest = pending_records.pop_front();
               check_field("hr_out_bpm", 32'(rsp_hr_out_bpm), 32'(oldest.hr_bpm));
               check_field("hr_from_ppg", 32'(rsp_hr_from_ppg), 32'(oldest.from_ppg));
               check_field("ecg_leads_off", 32'(rsp_ecg_leads_off),
                           32'(oldest.lead_off_flag));
               check_field("ppg_weak", 32'(rsp_ppg_weak), 32'(oldest.poor_ppg));
               check_field("spo2_x10", 32'(rsp_spo2_x10), 32'(oldest.spo2_scaled));
               check_field("sdnn_out_ms", 32'(rsp_sdnn_out_ms), 32'(oldest.sdnn_ms));
               check_field("rmssd_out_ms", 32'(rsp_rmssd_out_ms), 32'(oldest.rmssd_ms));
               check_field("lf_hf_out_x10", 32'(rsp_lf_hf_out_x10), 32'(oldest.lf_hf_x10));
            end
         end
      end
      records_waiting = pending_records.size();
   end

endmodule

// ===== sim/heart_rate_source_arbiter_test.sv =====
// Testbench top for the heart-rate source arbiter: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module heart_rate_source_arbiter_test;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned PHASES = 5;
   localparam int unsigned RANDOM_PER_PHASE = 200;

   // Indexes that name no register; writes to them must change nothing.
   localparam logic [hra_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [hra_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [31:0] now_ms;
      logic [7:0]  lead_mask;
      logic [31:0] lead_age_ms;
      logic [15:0] rate_bpm;
      logic [15:0] sdnn_ms;
      logic [15:0] rmssd_ms;
      logic        freq_valid;
      logic [7:0]  lf_hf_x10;
      logic [7:0]  spo2_pct;
      logic        low_perf;
      logic        finger_off;
   } vitals_msg_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_cmd = 1'b0;
   logic [31:0]                         req_now_ms = '0;
   logic [7:0]                          req_lead_mask = '0;
   logic [31:0]                         req_lead_mask_age_ms = '0;
   logic [15:0]                         req_rate_bpm = '0;
   logic [15:0]                         req_sdnn_ms = '0;
   logic [15:0]                         req_rmssd_ms = '0;
   logic                                req_freq_valid = 1'b0;
   logic [7:0]                          req_lf_hf_ratio_x10 = '0;
   logic [7:0]                          req_spo2_pct = '0;
   logic                                req_low_perfusion = 1'b0;
   logic                                req_finger_off = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [15:0]                         rsp_hr_out_bpm;
   logic                                rsp_hr_from_ppg;
   logic                                rsp_ecg_leads_off;
   logic                                rsp_ppg_weak;
   logic [11:0]                         rsp_spo2_x10;
   logic [15:0]                         rsp_sdnn_out_ms;
   logic [15:0]                         rsp_rmssd_out_ms;
   logic [7:0]                          rsp_lf_hf_out_x10;
   logic                                csr_we = 1'b0;
   logic [hra_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [hra_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int fail_count;
   int records_waiting;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic [15:0] hr_limit_now = hra_pkg::STALE_LIMIT_RESET;
   logic [15:0] lead_limit_now = hra_pkg::STALE_LIMIT_RESET;
   logic [31:0] uptime = '0;

   int unsigned quiet_cycles = 0;
   int unsigned requests_taken = 0;
   int unsigned ppg_requests = 0;
   int unsigned ecg_picks = 0;
   int unsigned ppg_picks = 0;
   int unsigned no_rate = 0;
   int unsigned limit_settings = 1;

   heart_rate_source_arbiter dut (.*);

   vitals_merge_checker u_checker (.*);

   always #6 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // Watchdog on handshakes, plus a tally of what the run went through.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         requests_taken++;
         if (req_cmd == hra_pkg::CMD_PPG) ppg_requests++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_hr_from_ppg) ppg_picks++;
         else if (rsp_hr_out_bpm != 16'd0) ecg_picks++;
         else no_rate++;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d records outstanding",
                  QUIET_LIMIT, records_waiting);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   function automatic vitals_msg_type vitals(
      input logic cmd, input logic [31:0] now_ms, input logic [7:0] mask,
      input logic [31:0] age, input logic [15:0] rate, input logic [15:0] sdnn,
      input logic [15:0] rmssd, input logic fv, input logic [7:0] lf_hf,
      input logic [7:0] spo2, input logic low_perf, input logic finger_off);
      vitals_msg_type m;
      m = '{cmd, now_ms, mask, age, rate, sdnn, rmssd, fv, lf_hf, spo2, low_perf, finger_off};
      return m;
   endfunction

   // A spread of time gaps that lands on, just past, well inside and far beyond a limit.
   function automatic logic [31:0] pick_gap(input logic [15:0] limit);
      logic [31:0] lim;
      lim = {16'd0, limit};
      case ($urandom_range(7))
         0: return 32'd0;
         1: return lim;
         2: return lim + 32'd1;
         3, 4: return $urandom_range(lim);
         5: return $urandom_range(2 * lim + 2);
         6: return $urandom;
         default: return $urandom_range(lim >> 2);
      endcase
   endfunction

   task automatic next_random_msg(output vitals_msg_type m);
      if ($urandom_range(3) == 0) uptime += pick_gap(hr_limit_now);
      else uptime += $urandom_range({16'd0, hr_limit_now} / 3);
      m.cmd = $urandom_range(1) ? hra_pkg::CMD_PPG : hra_pkg::CMD_ECG;
      m.now_ms = uptime;
      m.lead_mask = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1));
      m.lead_age_ms = pick_gap(lead_limit_now);
      case ($urandom_range(7))
         0: m.rate_bpm = 16'd0;
         1: m.rate_bpm = 16'hFFFF;
         2: m.rate_bpm = 16'($urandom);
         default: m.rate_bpm = 16'($urandom_range(200, 40));
      endcase
      m.sdnn_ms = 16'($urandom);
      m.rmssd_ms = 16'($urandom);
      m.freq_valid = 1'($urandom_range(1));
      m.lf_hf_x10 = 8'($urandom);
      m.spo2_pct = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(100, 85));
      m.low_perf = ($urandom_range(7) == 0);
      m.finger_off = ($urandom_range(7) == 0);
   endtask

   // Entered and left just after a falling edge.
   task automatic push_request(input vitals_msg_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= m.cmd;
      req_now_ms <= m.now_ms;
      req_lead_mask <= m.lead_mask;
      req_lead_mask_age_ms <= m.lead_age_ms;
      req_rate_bpm <= m.rate_bpm;
      req_sdnn_ms <= m.sdnn_ms;
      req_rmssd_ms <= m.rmssd_ms;
      req_freq_valid <= m.freq_valid;
      req_lf_hf_ratio_x10 <= m.lf_hf_x10;
      req_spo2_pct <= m.spo2_pct;
      req_low_perfusion <= m.low_perf;
      req_finger_off <= m.finger_off;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Limits only change once the block has delivered everything and gone quiet.
   task automatic set_limits(input logic [15:0] hr, input logic [15:0] lead);
      req_valid <= 1'b0;
      while (records_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= hra_pkg::CSR_HR_STALE_LIMIT;
      csr_wdata <= hr;
      @(negedge clock);
      csr_index <= hra_pkg::CSR_LEAD_STALE_LIMIT;
      csr_wdata <= lead;
      @(negedge clock);
      csr_index <= $urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO;
      csr_wdata <= 16'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      hr_limit_now = hr;
      lead_limit_now = lead;
      limit_settings++;
   endtask

   initial begin
      vitals_msg_type m;
      int unsigned p;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed requests under the reset limits of 5000 ms; no PPG rate stored yet.
      push_request(vitals(hra_pkg::CMD_ECG, 32'd1000, 8'h00, 32'd0, 16'd72, 16'hFFFF,
                          16'h0000, 1'b1, 8'hFF, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd1500, 8'h00, 32'hFFFF_FFFF, 16'hFFFF,
                          16'h0000, 16'hFFFF, 1'b0, 8'hAA, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd2000, 8'hFF, 32'd5000, 16'd80, 16'd40,
                          16'd30, 1'b1, 8'd20, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd2100, 8'h01, 32'd5001, 16'd81, 16'd41,
                          16'd31, 1'b1, 8'h55, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'd7100, 8'h00, 32'd0, 16'hFFFF, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd255, 1'b1, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'd7101, 8'h00, 32'd0, 16'd95, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd0, 1'b0, 1'b1));
      push_request(vitals(hra_pkg::CMD_PPG, 32'd7102, 8'h00, 32'd0, 16'd0, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd98, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'd8000, 8'h00, 32'd0, 16'd60, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd97, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd8000, 8'h00, 32'd0, 16'd0, 16'd50,
                          16'd45, 1'b1, 8'd12, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd8001, 8'h80, 32'd0, 16'd70, 16'd51,
                          16'd46, 1'b1, 8'd13, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'd13000, 8'h00, 32'd0, 16'd75, 16'd52,
                          16'd47, 1'b1, 8'd14, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'd13001, 8'h00, 32'd0, 16'd0, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd96, 1'b1, 1'b1));
      // Across the wrap of the millisecond counter.
      push_request(vitals(hra_pkg::CMD_ECG, 32'hFFFF_F000, 8'h00, 32'd0, 16'd88, 16'd60,
                          16'd55, 1'b1, 8'h0F, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'h0000_0100, 8'h00, 32'd0, 16'd66, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd100, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_ECG, 32'h0000_1000, 8'h7F, 32'hFFFF_FFFF, 16'h8000,
                          16'd61, 16'd56, 1'b0, 8'hF0, 8'd0, 1'b0, 1'b0));
      push_request(vitals(hra_pkg::CMD_PPG, 32'h0000_2000, 8'hFF, 32'd0, 16'd0, 16'd0,
                          16'd0, 1'b0, 8'd0, 8'd99, 1'b1, 1'b1));
      uptime = 32'h0000_2000;

      for (p = 0; p < PHASES; p++) begin
         case (p)
            1: set_limits(16'd0, 16'hFFFF);
            2: set_limits(16'hFFFF, 16'd0);
            3: set_limits(16'($urandom), 16'($urandom));
            4: set_limits(16'($urandom_range(3000)), 16'($urandom_range(3000)));
            default: ;
         endcase
         case (p)
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            3: begin send_idle_pct = 8; recv_stall_pct = 8; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            next_random_msg(m);
            push_request(m);
         end
      end

      req_valid <= 1'b0;
      while (records_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d requests (%0d ECG, %0d PPG) in %0d handshake phases "
               , requests_taken, requests_taken - ppg_requests, ppg_requests, PHASES);
      $display("with %0d limit settings; records took ECG %0d, PPG %0d, no rate %0d times.",
               limit_settings, ecg_picks, ppg_picks, no_rate);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
